FILE: design/cbsf_pkg.sv
// Package for the byte stream filter: character codes, configuration
// register indexes and the command word passed from front end to back end.
// No dependencies.
`default_nettype none

package cbsf_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL        = 8'd10;
  localparam logic [BYTE_W-1:0] CH_VT        = 8'd11;
  localparam logic [BYTE_W-1:0] CH_US        = 8'd31;
  localparam logic [BYTE_W-1:0] CH_BS        = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [BYTE_W-1:0] CH_DOLLAR    = 8'd36;
  localparam logic [BYTE_W-1:0] CH_ZERO      = 8'd48;
  localparam logic [BYTE_W-1:0] CH_QMARK     = 8'd63;
  localparam logic [BYTE_W-1:0] CH_I         = 8'd73;
  localparam logic [BYTE_W-1:0] CH_CARET     = 8'd94;
  localparam logic [BYTE_W-1:0] CH_DEL       = 8'd127;
  localparam logic [BYTE_W-1:0] CARET_OFFSET = 8'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_ENDS        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_TABS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOW_NONPRINTING = 3'd4;

  localparam logic [1:0] NUM_OFF = 2'd0;
  localparam logic [1:0] NUM_ALL = 2'd1;

  localparam logic [1:0] RUN_MAX = 2'd3;

  typedef struct packed {
    logic              num_due;
    logic              dollar;
    logic              pair;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
  } cbsf_cmd_t;

  localparam int unsigned CMD_W = $bits(cbsf_cmd_t);

endpackage

`default_nettype wire

FILE: design/cbsf_in_if.sv
// Input byte channel: valid/ready handshake with one raw text byte.
// Depends on cbsf_pkg.
`default_nettype none

interface cbsf_in_if;
  import cbsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: design/cbsf_out_if.sv
// Result channel: valid/ready handshake with one output byte and last flag.
// Depends on cbsf_pkg.
`default_nettype none

interface cbsf_out_if;
  import cbsf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

FILE: design/cbsf_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on cbsf_pkg.
`default_nettype none

interface cbsf_cfg_if;
  import cbsf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/cat_byte_stream_filter_top.sv
// Line-numbering text filter in the style of cat with its display options.
// Accepts one byte per cycle; a byte that expands into n output bytes
// (line number of NUMBER_DIGITS places plus tab, '$', caret pairs; up to
// NUMBER_DIGITS+3) keeps the output sequencer busy until all n are out, so
// plain text runs at one byte per cycle while the output is ready, and expanded
// bytes stall the input once the two-entry command queue fills. Configuration
// writes are always ready and must only be issued while the filter is idle.
// Depends on cbsf_pkg, the channel interfaces, cbsf_front, cbsf_queue, cbsf_back.
`default_nettype none

module cat_byte_stream_filter_top #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cbsf_in_if.sink    in_if,
  cbsf_out_if.source out_if,
  cbsf_cfg_if.sink   cfg_if
);
  import cbsf_pkg::*;

  localparam int unsigned BCD_W = 4 * NUMBER_DIGITS;
  localparam int unsigned Q_W   = CMD_W + BCD_W;

  logic              q_full, q_push, q_pop, q_valid;
  cbsf_cmd_t         f_cmd, b_cmd;
  logic [BCD_W-1:0]  f_bcd, b_bcd;
  logic [Q_W-1:0]    q_rd;

  assign cfg_if.ready = 1'b1;

  cbsf_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_if.valid),
    .cfg_index (cfg_if.index),
    .cfg_data  (cfg_if.data),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_byte   (in_if.in_byte),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (f_cmd),
    .q_bcd     (f_bcd)
  );

  cbsf_queue #(.WIDTH(Q_W)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_data  ({f_cmd, f_bcd}),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_rd)
  );

  assign b_cmd = q_rd[Q_W-1:BCD_W];
  assign b_bcd = q_rd[BCD_W-1:0];

  cbsf_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (b_cmd),
    .q_bcd     (b_bcd),
    .q_pop     (q_pop),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_byte  (out_if.out_byte),
    .out_last  (out_if.last)
  );

endmodule

`default_nettype wire

FILE: design/cbsf_front.sv
// Front end: option registers, previous byte, newline run and BCD line
// counter; classifies each accepted byte into a command word. Uses cbsf_pkg.
`default_nettype none

module cbsf_front #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [cbsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cbsf_pkg::CFG_DAT_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [cbsf_pkg::BYTE_W-1:0]    in_byte,
  input  wire logic                           q_full,
  output logic                                q_push,
  output cbsf_pkg::cbsf_cmd_t                 q_cmd,
  output logic [4*NUMBER_DIGITS-1:0]          q_bcd
);
  import cbsf_pkg::*;

  localparam int unsigned BCD_W = 4 * NUMBER_DIGITS;
  localparam logic [BCD_W-1:0] BCD_ONE = BCD_W'(1);

  logic [1:0] number_mode_r;
  logic       squeeze_blank_r;
  logic       show_ends_r;
  logic       show_tabs_r;
  logic       show_np_r;

  logic [BYTE_W-1:0]                  prev_r;
  logic [1:0]                         run_r, run_nxt;
  logic [NUMBER_DIGITS-1:0][3:0]      cnt_r, cnt_inc;
  logic                               cnt_full;
  logic                               accept, is_nl, squeeze, num_due;
  logic                               ctrl_byte;
  logic [NUMBER_DIGITS:0]             carry;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_nl    = (in_byte == CH_NL);

  always_comb begin
    if (is_nl) begin
      run_nxt = (run_r == RUN_MAX) ? RUN_MAX : run_r + 2'd1;
    end else begin
      run_nxt = 2'd0;
    end
  end

  // third and later newline in a row: run was already two or more
  assign squeeze = squeeze_blank_r && is_nl && (run_r >= 2'd2);

  always_comb begin
    unique case (number_mode_r)
      NUM_OFF: num_due = 1'b0;
      NUM_ALL: num_due = (prev_r == CH_NL);
      default: num_due = (prev_r == CH_NL) && !is_nl;
    endcase
  end

  // BCD increment, holds at all nines
  always_comb begin
    carry[0] = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry[i]) begin
        cnt_inc[i] = (cnt_r[i] == 4'd9) ? 4'd0 : cnt_r[i] + 4'd1;
      end else begin
        cnt_inc[i] = cnt_r[i];
      end
      carry[i+1] = carry[i] && (cnt_r[i] == 4'd9);
    end
    cnt_full = carry[NUMBER_DIGITS];
  end

  assign ctrl_byte = (in_byte <= CH_BS) || ((in_byte >= CH_VT) && (in_byte <= CH_US));

  always_comb begin
    q_cmd.num_due = num_due;
    q_cmd.dollar  = show_ends_r && is_nl;
    q_cmd.pair    = 1'b0;
    q_cmd.b0      = in_byte;
    q_cmd.b1      = CH_CARET;
    priority if (show_tabs_r && (in_byte == CH_TAB)) begin
      q_cmd.pair = 1'b1;
      q_cmd.b0   = CH_CARET;
      q_cmd.b1   = CH_I;
    end else if (show_np_r && ctrl_byte) begin
      q_cmd.pair = 1'b1;
      q_cmd.b0   = CH_CARET;
      q_cmd.b1   = in_byte + CARET_OFFSET;
    end else if (show_np_r && (in_byte == CH_DEL)) begin
      q_cmd.pair = 1'b1;
      q_cmd.b0   = CH_CARET;
      q_cmd.b1   = CH_QMARK;
    end else begin
      q_cmd.pair = 1'b0;
    end
  end

  assign q_bcd  = cnt_r;
  assign q_push = accept && !squeeze;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r   <= NUM_OFF;
      squeeze_blank_r <= 1'b0;
      show_ends_r     <= 1'b0;
      show_tabs_r     <= 1'b0;
      show_np_r       <= 1'b0;
      prev_r          <= CH_NL;
      run_r           <= 2'd1;
      cnt_r           <= BCD_ONE;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUMBER_MODE:      number_mode_r   <= cfg_data[1:0];
          CFG_SQUEEZE_BLANK:    squeeze_blank_r <= cfg_data[0];
          CFG_SHOW_ENDS:        show_ends_r     <= cfg_data[0];
          CFG_SHOW_TABS:        show_tabs_r     <= cfg_data[0];
          CFG_SHOW_NONPRINTING: show_np_r       <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        run_r <= run_nxt;
        if (!squeeze) begin
          prev_r <= in_byte;
          if (num_due && !cnt_full) begin
            cnt_r <= cnt_inc;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/cbsf_queue.sv
// Two-entry command queue between front and back end; push and pop may
// happen in the same cycle. No package dependency.
`default_nettype none

module cbsf_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  rd_valid,
  output logic [WIDTH-1:0]      rd_data
);

  logic [1:0][WIDTH-1:0] mem_r;
  logic                  wr_ptr_r, rd_ptr_r;
  logic [1:0]            cnt_r;

  assign full     = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      priority if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end else begin
        cnt_r <= cnt_r;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/cbsf_back.sv
// Back end: steps through one command word (number digits, tab, dollar,
// character bytes) into the output register, a byte per cycle while it is free. Uses cbsf_pkg.
`default_nettype none

module cbsf_back #(
  parameter int unsigned NUMBER_DIGITS = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_valid,
  input  wire cbsf_pkg::cbsf_cmd_t         q_cmd,
  input  wire logic [4*NUMBER_DIGITS-1:0]  q_bcd,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cbsf_pkg::BYTE_W-1:0]      out_byte,
  output logic                             out_last
);
  import cbsf_pkg::*;

  localparam int unsigned IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NUMBER_DIGITS - 1);

  typedef enum logic [4:0] {
    PH_DIGIT  = 5'b00001,
    PH_TAB    = 5'b00010,
    PH_DOLLAR = 5'b00100,
    PH_CHAR0  = 5'b01000,
    PH_CHAR1  = 5'b10000
  } phase_t;

  phase_t                        phase_r, cur_phase, phase_nxt;
  logic                          busy_r;
  logic [IDX_W-1:0]              idx_r, cur_idx, idx_nxt;
  logic [NUMBER_DIGITS-1:0][3:0] digits;
  logic [NUMBER_DIGITS-1:0]      shown;
  logic                          emit, done;
  logic [BYTE_W-1:0]             byte_sel;
  logic                          out_valid_r, out_last_r;
  logic [BYTE_W-1:0]             out_byte_r;

  assign digits = q_bcd;

  // digit is printed once a non-zero digit is seen from the top; lowest always is
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
      seen     = seen || (digits[i] != 4'd0) || (i == 0);
      shown[i] = seen;
    end
  end

  always_comb begin
    if (busy_r) begin
      cur_phase = phase_r;
      cur_idx   = idx_r;
    end else begin
      cur_idx = IDX_TOP;
      priority if (q_cmd.num_due) begin
        cur_phase = PH_DIGIT;
      end else if (q_cmd.dollar) begin
        cur_phase = PH_DOLLAR;
      end else begin
        cur_phase = PH_CHAR0;
      end
    end
  end

  always_comb begin
    byte_sel  = q_cmd.b0;
    phase_nxt = cur_phase;
    idx_nxt   = cur_idx;
    done      = 1'b0;
    unique case (cur_phase)
      PH_DIGIT: begin
        byte_sel = shown[cur_idx] ? (CH_ZERO + {4'd0, digits[cur_idx]}) : CH_SPACE;
        if (cur_idx == '0) begin
          phase_nxt = PH_TAB;
        end else begin
          idx_nxt = cur_idx - IDX_W'(1);
        end
      end
      PH_TAB: begin
        byte_sel  = CH_TAB;
        phase_nxt = q_cmd.dollar ? PH_DOLLAR : PH_CHAR0;
      end
      PH_DOLLAR: begin
        byte_sel  = CH_DOLLAR;
        phase_nxt = PH_CHAR0;
      end
      PH_CHAR0: begin
        byte_sel  = q_cmd.b0;
        phase_nxt = PH_CHAR1;
        done      = !q_cmd.pair;
      end
      PH_CHAR1: begin
        byte_sel = q_cmd.b1;
        done     = 1'b1;
      end
      default: begin
        byte_sel = q_cmd.b0;
        done     = 1'b1;
      end
    endcase
  end

  assign emit  = q_valid && (!out_valid_r || out_ready);
  assign q_pop = emit && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_CHAR0;
      idx_r       <= IDX_TOP;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        busy_r      <= !done;
        phase_r     <= phase_nxt;
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

FILE: bench/cat_byte_stream_filter_top_tb.sv
// Self-checking bench for cat_byte_stream_filter_top: directed and random text through
// a local line-number/caret predictor, with random stalls on both channels.
// Depends on cbsf_pkg, the three channel interfaces and the filter top level.
`default_nettype none

module cat_byte_stream_filter_top_tb;
  import cbsf_pkg::*;

  localparam int unsigned DIGITS = 6;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [4*DIGITS-1:0] ALL_NINES = {DIGITS{4'h9}};
  localparam logic [1:0] NUM_NONBLANK = 2'd2;
  localparam logic [1:0] NUM_NONBLANK_ALT = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } filter_result_t;

  logic clk;
  logic rst_n;

  cbsf_in_if  in_ch ();
  cbsf_out_if out_ch ();
  cbsf_cfg_if cfg_ch ();

  cat_byte_stream_filter_top #(
    .NUMBER_DIGITS(DIGITS)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  // predictor state and configuration copy
  logic [1:0]          cfg_mode = NUM_OFF;
  logic                cfg_squeeze = 1'b0;
  logic                cfg_ends = 1'b0;
  logic                cfg_tabs = 1'b0;
  logic                cfg_nonprint = 1'b0;
  logic [BYTE_W-1:0]   prev_byte = CH_NL;
  logic [4*DIGITS-1:0] line_bcd = (4*DIGITS)'(1);
  logic [1:0]          nl_run = 2'd1;

  filter_result_t expected_text[$];

  int failures = 0;
  int bytes_sent = 0;
  int bytes_checked = 0;
  int settings_used = 0;
  int squeezed_count = 0;

  logic tx_random = 1'b1;
  logic rx_random = 1'b1;
  int   rx_hold = 0;
  int   rx_stall = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Timeout with %0d transfers still expected", expected_text.size());
    $display("FAIL cat_byte_stream_filter_top");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [BYTE_W-1:0] text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return BYTE_W'($urandom_range(32, 126));
    if (r < 60) return CH_NL;
    if (r < 68) return CH_TAB;
    if (r < 80) return BYTE_W'($urandom_range(0, 31));
    if (r < 85) return CH_DEL;
    return BYTE_W'($urandom_range(128, 255));
  endfunction

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  task automatic filter_predict(input logic [BYTE_W-1:0] ch);
    logic [BYTE_W-1:0] outb [0:DIGITS+3];
    filter_result_t    r;
    int                n;
    logic              due;
    logic              started;
    logic              carry;
    logic [3:0]        d;
    n = 0;
    if (ch == CH_NL) begin
      if (nl_run != RUN_MAX) nl_run = nl_run + 2'd1;
    end else begin
      nl_run = 2'd0;
    end
    if (cfg_squeeze && nl_run > 2'd2) begin
      squeezed_count++;
      return;
    end
    case (cfg_mode)
      NUM_OFF: due = 1'b0;
      NUM_ALL: due = (prev_byte == CH_NL);
      default: due = (prev_byte == CH_NL) && (ch != CH_NL);
    endcase
    if (due) begin
      started = 1'b0;
      for (int i = DIGITS - 1; i >= 0; i--) begin
        d = line_bcd[4*i +: 4];
        if (d != 4'd0 || i == 0) started = 1'b1;
        outb[n] = started ? (CH_ZERO + BYTE_W'(d)) : CH_SPACE;
        n++;
      end
      outb[n] = CH_TAB;
      n++;
      if (line_bcd != ALL_NINES) begin
        carry = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
          if (carry) begin
            if (line_bcd[4*i +: 4] == 4'd9) begin
              line_bcd[4*i +: 4] = 4'd0;
            end else begin
              line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'd1;
              carry = 1'b0;
            end
          end
        end
      end
    end
    if (cfg_ends && ch == CH_NL) begin
      outb[n] = CH_DOLLAR;
      n++;
    end
    if (cfg_tabs && ch == CH_TAB) begin
      outb[n] = CH_CARET;
      outb[n+1] = CH_I;
      n += 2;
    end else if (cfg_nonprint && (ch <= CH_BS || (ch >= CH_VT && ch <= CH_US))) begin
      outb[n] = CH_CARET;
      outb[n+1] = ch + CARET_OFFSET;
      n += 2;
    end else if (cfg_nonprint && ch == CH_DEL) begin
      outb[n] = CH_CARET;
      outb[n+1] = CH_QMARK;
      n += 2;
    end else begin
      outb[n] = ch;
      n++;
    end
    prev_byte = ch;
    for (int k = 0; k < n; k++) begin
      r.b = outb[k];
      r.last = (k == n - 1);
      expected_text.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = (tx_random && $urandom_range(0, 99) < 30) ? gap_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    filter_predict(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_NUMBER_MODE:      cfg_mode = val[1:0];
      CFG_SQUEEZE_BLANK:    cfg_squeeze = val[0];
      CFG_SHOW_ENDS:        cfg_ends = val[0];
      CFG_SHOW_TABS:        cfg_tabs = val[0];
      CFG_SHOW_NONPRINTING: cfg_nonprint = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_config(input logic [1:0] mode, input logic sq, input logic ends,
                              input logic tabs, input logic np);
    wait_idle();
    cfg_write(CFG_NUMBER_MODE, {6'd0, mode});
    cfg_write(CFG_SQUEEZE_BLANK, {7'd0, sq});
    cfg_write(CFG_SHOW_ENDS, {7'd0, ends});
    cfg_write(CFG_SHOW_TABS, {7'd0, tabs});
    cfg_write(CFG_SHOW_NONPRINTING, {7'd0, np});
    settings_used++;
  endtask

  // receiver: random stalls plus an explicit long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        out_ch.ready <= 1'b0;
        rx_stall--;
      end else if (rx_random && $urandom_range(0, 99) < 25) begin
        out_ch.ready <= 1'b0;
        rx_stall = gap_len() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_transfer
    filter_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_text.size() == 0) begin
        report_failure($sformatf("unexpected transfer byte=%0d last=%0b",
                                 out_ch.out_byte, out_ch.last));
      end else begin
        want = expected_text.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== want.b || out_ch.last !== want.last)
          report_failure($sformatf("byte exp %0d got %0d, last exp %0b got %0b",
                                   want.b, out_ch.out_byte, want.last, out_ch.last));
      end
    end
  end

  task automatic test_plain_text();
    apply_config(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(8'd0);
    send_byte(8'd255);
    send_byte("A");
    send_byte(CH_TAB);
    send_byte(CH_NL);
    send_byte(CH_DEL);
    send_byte(CH_US);
  endtask

  task automatic test_show_options();
    apply_config(NUM_OFF, 1'b0, 1'b1, 1'b1, 1'b1);
    send_byte(CH_TAB);
    send_byte(CH_NL);
    send_byte(8'd0);
    send_byte(CH_BS);
    send_byte(CH_VT);
    send_byte(CH_US);
    send_byte(CH_DEL);
    send_byte(8'd128);
    send_byte("x");
    apply_config(NUM_OFF, 1'b0, 1'b0, 1'b0, 1'b1);
    send_byte(CH_TAB);
    send_byte(CH_NL);
  endtask

  task automatic test_numbering();
    apply_config(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte("a");
    send_byte(CH_NL);
    send_byte(CH_NL);
    apply_config(NUM_NONBLANK, 1'b0, 1'b1, 1'b0, 1'b0);
    send_byte(CH_NL);
    send_byte("b");
    send_byte(CH_NL);
    apply_config(NUM_NONBLANK_ALT, 1'b0, 1'b0, 1'b0, 1'b0);
    send_byte(CH_NL);
    send_byte("c");
  endtask

  task automatic test_squeeze();
    apply_config(NUM_ALL, 1'b1, 1'b1, 1'b0, 1'b0);
    send_byte(CH_NL);
    repeat (4) send_byte(CH_NL);
    send_byte("d");
    repeat (3) send_byte(CH_NL);
  endtask

  task automatic test_spare_register();
    wait_idle();
    cfg_write(CFG_SPARE, 8'hFF);
    send_byte("e");
    send_byte(CH_NL);
  endtask

  task automatic test_counter_carry();
    apply_config(NUM_ALL, 1'b0, 1'b0, 1'b0, 1'b0);
    repeat (90) send_byte(CH_NL);
  endtask

  task automatic test_backpressure();
    apply_config(NUM_ALL, 1'b0, 1'b1, 1'b1, 1'b1);
    tx_random = 1'b0;
    @(negedge clk);
    rx_hold = 200;
    for (int i = 0; i < 30; i++) send_byte((i % 2 == 0) ? CH_NL : text_byte());
    tx_random = 1'b1;
  endtask

  task automatic test_random_text();
    logic [1:0] mode;
    int         burst;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p == 0) begin
        mode = NUM_OFF;
        cfg_write(CFG_NUMBER_MODE, 8'd0);
        for (int i = 1; i < 5; i++) cfg_write(CFG_IDX_W'(i), 8'd0);
        cfg_squeeze = 1'b0;
      end else if (p == 5) begin
        cfg_write(CFG_NUMBER_MODE, {6'd0, NUM_NONBLANK_ALT});
        for (int i = 1; i < 5; i++) cfg_write(CFG_IDX_W'(i), 8'hFF);
      end else begin
        mode = 2'($urandom_range(0, 3));
        cfg_write(CFG_NUMBER_MODE, (CFG_DAT_W'($urandom) & 8'hFC) | {6'd0, mode});
        for (int i = 1; i < 5; i++)
          cfg_write(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
      end
      settings_used++;
      tx_random = (p != 2);
      rx_random = (p != 3);
      for (int i = 0; i < 16; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          burst = $urandom_range(2, 5);
          repeat (burst) send_byte(CH_NL);
        end else begin
          send_byte(text_byte());
        end
      end
    end
    tx_random = 1'b1;
    rx_random = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_text();
    test_show_options();
    test_numbering();
    test_squeeze();
    test_spare_register();
    test_counter_carry();
    test_backpressure();
    test_random_text();
    wait_idle();

    if (expected_text.size() != 0)
      report_failure($sformatf("%0d transfers never arrived", expected_text.size()));
    $display("Sent %0d bytes under %0d option settings, checked %0d output bytes",
             bytes_sent, settings_used, bytes_checked);
    $display("Squeezed %0d blank lines; %0d failures", squeezed_count, failures);
    if (failures == 0) begin
      $display("PASS cat_byte_stream_filter_top");
    end else begin
      $display("FAIL cat_byte_stream_filter_top");
    end
    $finish;
  end

endmodule

`default_nettype wire
